/* rtl/core/scpg_pkg.sv */
// Shared types and codes for the stepper command pulse generator.
package scpg_pkg;

    localparam int ActionWidth  = 2;
    localparam int CmdWidth     = 8;
    localparam int PulsesWidth  = 10;
    localparam int HalfWidth    = 11;
    localparam int SpeedWidth   = 8;
    localparam int TdataOutBits = 16;

    typedef enum logic [ActionWidth-1:0] {
        ACT_TICK   = 2'd0,
        ACT_CMD    = 2'd1,
        ACT_TOGGLE = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    localparam logic [CmdWidth-1:0] CMD_SHORT   = 8'h01;
    localparam logic [CmdWidth-1:0] CMD_LONG    = 8'h02;
    localparam logic [CmdWidth-1:0] CMD_SLOWER  = 8'h07;
    localparam logic [CmdWidth-1:0] CMD_FASTER  = 8'h08;
    localparam logic [CmdWidth-1:0] CMD_REVERSE = 8'h09;

    localparam logic [SpeedWidth-1:0] SPEED_MIN   = 8'd1;
    localparam logic [SpeedWidth-1:0] SPEED_MAX   = 8'd255;
    localparam logic [SpeedWidth-1:0] SPEED_RESET = 8'd7;

    localparam logic [PulsesWidth-1:0] SHORT_RESET = 10'd100;
    localparam logic [PulsesWidth-1:0] LONG_RESET  = 10'd500;

    typedef enum logic {
        REG_SHORT = 1'b0,
        REG_LONG  = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic                  dropped;
        logic                  busy_res;
        logic [SpeedWidth-1:0] report_speed;
        logic                  report_valid;
        logic                  dir_level;
        logic                  step_level;
    } result_t;

endpackage

/* rtl/core/stepper_command_pulse_generator.sv */
// Top level: stepper command pulse generator with output skid buffer.
//
//  channel | dir | fields
//  --------+-----+-----------------------------------------------------------
//  s_*     | in  | tuser: action; tdata: command_byte
//  m_*     | out | tdata: step, dir, report_valid, report_speed, busy, dropped
//  cfg_*   | in  | write: 0 short_move_pulses, 1 long_move_pulses
//
//  One beat per cycle while s_tready is high; the result is registered.
//  A two-entry output buffer (result + skid) lets a beat enter while a result waits.
//  s_tready drops only when both entries are full.
//  Reset: asynchronous, active low; clears motion state and both entries.
module stepper_command_pulse_generator
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [9:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] command_byte
    input  logic [1:0]  s_tuser,   // [1:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [0] step_level, [1] dir_level, [2] report_valid,
                                   // [10:3] report_speed, [11] busy_res, [12] dropped
);

    scpg_pkg::result_t result;
    scpg_pkg::result_t out_reg;
    scpg_pkg::result_t skid_reg;
    logic              out_valid_reg;
    logic              skid_valid_reg;
    logic              fire;

    assign s_tready = !skid_valid_reg;
    assign fire     = s_tvalid && s_tready;

    scpg_engine u_engine
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (scpg_pkg::reg_index_t'(cfg_index)),
        .cfg_data     (cfg_data),
        .beat_en      (fire),
        .action       (scpg_pkg::action_t'(s_tuser)),
        .command_byte (s_tdata),
        .result       (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= fire;
            end
        end
        else if (fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_tready)
        begin
            out_reg <= skid_valid_reg ? skid_reg : result;
        end
        else if (fire)
        begin
            skid_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_reg.dropped, out_reg.busy_res, out_reg.report_speed,
                       out_reg.report_valid, out_reg.dir_level, out_reg.step_level};

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output entry empty");

    a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !m_tready) |=> skid_valid_reg)
        else $error("skid entry lost during stall");

    a_drop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.dropped) |-> out_reg.busy_res)
        else $error("dropped beat reported while idle");

    a_speed_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.report_speed != '0))
        else $error("speed step reached zero");

endmodule

/* rtl/core/scpg_engine.sv */
// Motion state and per-beat update logic of the pulse generator.
module scpg_engine
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  scpg_pkg::reg_index_t               cfg_index,
    input  logic [scpg_pkg::PulsesWidth-1:0]   cfg_data,
    input  logic                               beat_en,
    input  scpg_pkg::action_t                  action,
    input  logic [scpg_pkg::CmdWidth-1:0]      command_byte,
    output scpg_pkg::result_t                  result
);

    logic [scpg_pkg::PulsesWidth-1:0] short_pulses_reg;
    logic [scpg_pkg::PulsesWidth-1:0] long_pulses_reg;

    logic [scpg_pkg::SpeedWidth-1:0] speed_reg, speed_next;
    logic                            dir_reg, dir_next;
    logic                            step_reg, step_next;
    logic [scpg_pkg::HalfWidth-1:0]  half_reg, half_next;
    logic [scpg_pkg::SpeedWidth-1:0] tick_reg, tick_next;
    logic                            cont_reg, cont_next;

    logic                            report;
    logic                            drop;
    logic [scpg_pkg::SpeedWidth-1:0] tick_inc;
    logic [scpg_pkg::HalfWidth-1:0]  half_dec;
    logic [scpg_pkg::PulsesWidth-1:0] pulses;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_pulses_reg <= scpg_pkg::SHORT_RESET;
            long_pulses_reg  <= scpg_pkg::LONG_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                scpg_pkg::REG_SHORT: short_pulses_reg <= cfg_data;
                scpg_pkg::REG_LONG:  long_pulses_reg  <= cfg_data;
                default:             short_pulses_reg <= short_pulses_reg;
            endcase
        end
    end

    always_comb
    begin
        speed_next = speed_reg;
        dir_next   = dir_reg;
        step_next  = step_reg;
        half_next  = half_reg;
        tick_next  = tick_reg;
        cont_next  = cont_reg;
        report     = 1'b0;
        drop       = 1'b0;
        tick_inc   = tick_reg + 8'd1;
        half_dec   = half_reg - 11'd1;
        pulses     = (command_byte == scpg_pkg::CMD_SHORT) ? short_pulses_reg
                                                           : long_pulses_reg;

        if (action == scpg_pkg::ACT_TICK)
        begin
            if (half_reg != '0 || cont_reg)
            begin
                if (tick_inc < speed_reg)
                begin
                    tick_next = tick_inc;
                end
                else
                begin
                    tick_next = '0;
                    if (half_reg != '0)
                    begin
                        half_next = half_dec;
                        if (half_dec != '0)
                            step_next = ~step_reg;
                    end
                    else
                    begin
                        step_next = ~step_reg;
                    end
                end
            end
        end
        else if (half_reg != '0)
        begin
            drop = 1'b1;
        end
        else if (action == scpg_pkg::ACT_TOGGLE)
        begin
            cont_next = ~cont_reg;
            tick_next = '0;
            step_next = cont_reg;
        end
        else if (action == scpg_pkg::ACT_CMD)
        begin
            case (command_byte) inside
                scpg_pkg::CMD_SHORT, scpg_pkg::CMD_LONG:
                begin
                    if (cont_reg)
                    begin
                        drop = 1'b1;
                    end
                    else if (pulses != '0)
                    begin
                        half_next = {pulses, 1'b0};
                        step_next = 1'b0;
                        tick_next = '0;
                    end
                end
                scpg_pkg::CMD_SLOWER:
                begin
                    if (speed_reg != scpg_pkg::SPEED_MAX)
                        speed_next = speed_reg + 8'd1;
                    report = 1'b1;
                end
                scpg_pkg::CMD_FASTER:
                begin
                    if (speed_reg != scpg_pkg::SPEED_MIN)
                        speed_next = speed_reg - 8'd1;
                    report = 1'b1;
                end
                scpg_pkg::CMD_REVERSE:
                begin
                    dir_next = ~dir_reg;
                end
                default:
                begin
                    drop = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg <= scpg_pkg::SPEED_RESET;
            dir_reg   <= 1'b1;
            step_reg  <= 1'b1;
            half_reg  <= '0;
            tick_reg  <= '0;
            cont_reg  <= 1'b0;
        end
        else if (beat_en)
        begin
            speed_reg <= speed_next;
            dir_reg   <= dir_next;
            step_reg  <= step_next;
            half_reg  <= half_next;
            tick_reg  <= tick_next;
            cont_reg  <= cont_next;
        end
    end

    assign result.step_level   = step_next;
    assign result.dir_level    = dir_next;
    assign result.report_valid = report;
    assign result.report_speed = speed_next;
    assign result.busy_res     = (half_next != '0) || cont_next;
    assign result.dropped      = drop;

endmodule
